### rtl/rational_arith_unit_core_assert.svh
// assertion macros
`ifndef RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define RAU_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst_n, a, c)
`define RAU_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/rau_pkg.sv
package rau_pkg;
	localparam int WIDTH_DEF = 32;
	localparam int PW = 66;
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_CMP = 3'd4;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;
	typedef enum logic [1:0] {
		K_ARITH,
		K_CMP,
		K_DONE
	} kind_t;
	typedef struct packed {
		kind_t kind;
		logic [2:0] op;
		logic [1:0] st;
		logic signed [32:0] an;
		logic [31:0] ad;
		logic signed [32:0] bn;
		logic [31:0] bd;
	} cmd_t;
	typedef enum logic [3:0] {
		B_IDLE,
		B_M1,
		B_M2,
		B_M3,
		B_M4,
		B_COMB,
		B_GCD,
		B_DIVN,
		B_DIVD,
		B_FIT,
		B_OUT
	} bstate_t;
endpackage

### rtl/rau_front.sv
`include "rational_arith_unit_core_assert.svh"
module rau_front #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] op,
	input logic [31:0] a_num,
	input logic [30:0] a_den,
	input logic [31:0] b_num,
	input logic [30:0] b_den,
	output logic q_valid,
	output rau_pkg::cmd_t q_cmd,
	input logic q_take
);
	localparam int DEPTH = 2;
	rau_pkg::cmd_t mem_q [DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	rau_pkg::cmd_t c;
	logic signed [WIDTH-1:0] an_w, bn_w;
	logic [WIDTH-2:0] ad_w, bd_w;
	logic wr, rd;

	always_comb begin
		an_w = a_num[WIDTH-1:0];
		bn_w = b_num[WIDTH-1:0];
		ad_w = a_den[WIDTH-2:0];
		bd_w = b_den[WIDTH-2:0];
		c.op = op;
		c.an = 33'(an_w);
		c.bn = 33'(bn_w);
		c.ad = 32'(ad_w);
		c.bd = 32'(bd_w);
		c.st = rau_pkg::ST_OK;
		c.kind = rau_pkg::K_DONE;
		if (op <= rau_pkg::OP_CMP && (ad_w == '0 || bd_w == '0)) begin
			c.st = rau_pkg::ST_DIVZERO;
		end else if (op == rau_pkg::OP_DIV && bn_w == '0) begin
			c.st = rau_pkg::ST_DIVZERO;
		end else if (op == rau_pkg::OP_CMP) begin
			c.kind = rau_pkg::K_CMP;
		end else if (op < rau_pkg::OP_CMP) begin
			c.kind = rau_pkg::K_ARITH;
		end
	end

	assign full = (cnt_q == 2'(DEPTH));
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = mem_q[rp_q];
	assign wr = push && !full;
	assign rd = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	`RAU_ASSERT_NXT(a_cnt_max, clk, arst_n, 1'b1, cnt_q <= 2'(DEPTH))
	`RAU_ASSERT_IMP(a_no_wr_full, clk, arst_n, full, !wr)
	`RAU_ASSERT_NXT(a_cnt_up, clk, arst_n, wr && !rd, cnt_q == $past(cnt_q) + 2'd1)
endmodule

### rtl/rau_back.sv
`include "rational_arith_unit_core_assert.svh"
module rau_back #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input rau_pkg::cmd_t q_cmd,
	output logic q_take,
	output logic empty,
	input logic pop,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic is_equal,
	output logic [1:0] status
);
	localparam int PW = rau_pkg::PW;
	localparam int CW = $clog2(PW + 1);
	rau_pkg::bstate_t st_q, st_d;
	rau_pkg::cmd_t cmd_q;
	logic signed [65:0] p1_q, p2_q, p3_q;
	logic [PW-1:0] nm_q, dm_q, gx_q, gy_q, g_q, rem_q, quo_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] rn_q, rd_q;
	logic [31:0] o_num_q;
	logic [30:0] o_den_q;
	logic o_eq_q;
	logic [1:0] o_st_q;
	logic [31:0] out_num_q;
	logic [30:0] out_den_q;
	logic out_eq_q;
	logic [1:0] out_st_q;
	logic o_full_q;
	logic signed [65:0] n_s, d_s, mul;
	logic signed [32:0] ma, mb;
	logic [PW:0] trial;
	logic [PW-1:0] lim, gdiff;
	logic start_out, gdone, out_free;

	always_comb begin
		ma = cmd_q.an;
		mb = 33'($signed({1'b0, cmd_q.bd}));
		unique case (st_q)
			rau_pkg::B_M2: begin
				ma = cmd_q.bn;
				mb = 33'($signed({1'b0, cmd_q.ad}));
			end
			rau_pkg::B_M3: begin
				ma = (cmd_q.op == rau_pkg::OP_MUL) ? cmd_q.bn :
					33'($signed({1'b0, cmd_q.ad}));
				mb = (cmd_q.op == rau_pkg::OP_MUL) ? cmd_q.an :
					((cmd_q.op == rau_pkg::OP_DIV) ? cmd_q.bn :
					33'($signed({1'b0, cmd_q.bd})));
			end
			rau_pkg::B_M4: begin
				ma = 33'($signed({1'b0, cmd_q.ad}));
				mb = 33'($signed({1'b0, cmd_q.bd}));
			end
			default: ;
		endcase
		mul = 66'(ma) * 66'(mb);
	end

	always_comb begin
		unique case (cmd_q.op)
			rau_pkg::OP_ADD: begin n_s = p1_q + p2_q; d_s = p3_q; end
			rau_pkg::OP_SUB: begin n_s = p1_q - p2_q; d_s = p3_q; end
			rau_pkg::OP_MUL: begin n_s = p2_q; d_s = p3_q; end
			default: begin n_s = p1_q; d_s = p3_q; end
		endcase
	end

	assign gdiff = (gx_q >= gy_q) ? gx_q - gy_q : gy_q - gx_q;
	assign gdone = (gx_q == '0);
	assign trial = {rem_q, quo_q[PW-1]} - {1'b0, g_q};
	assign lim = PW'(1) << (WIDTH - 1);
	assign empty = !o_full_q;
	assign out_free = !o_full_q || pop;
	assign start_out = (st_q == rau_pkg::B_OUT) && out_free;
	assign q_take = (st_q == rau_pkg::B_IDLE) && q_valid;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rau_pkg::B_IDLE: if (q_valid) st_d = (q_cmd.kind == rau_pkg::K_DONE) ?
				rau_pkg::B_OUT : rau_pkg::B_M1;
			rau_pkg::B_M1: st_d = rau_pkg::B_M2;
			rau_pkg::B_M2: st_d = (cmd_q.kind == rau_pkg::K_CMP) ? rau_pkg::B_OUT :
				rau_pkg::B_M3;
			rau_pkg::B_M3: st_d = (cmd_q.op == rau_pkg::OP_MUL) ? rau_pkg::B_M4 :
				rau_pkg::B_COMB;
			rau_pkg::B_M4: st_d = rau_pkg::B_COMB;
			rau_pkg::B_COMB: st_d = rau_pkg::B_GCD;
			rau_pkg::B_GCD: if (gdone) st_d = rau_pkg::B_DIVN;
			rau_pkg::B_DIVN: if (cnt_q == CW'(PW)) st_d = rau_pkg::B_DIVD;
			rau_pkg::B_DIVD: if (cnt_q == CW'(PW)) st_d = rau_pkg::B_FIT;
			rau_pkg::B_FIT: st_d = rau_pkg::B_OUT;
			rau_pkg::B_OUT: if (out_free) st_d = rau_pkg::B_IDLE;
			default: st_d = rau_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rau_pkg::B_IDLE;
			o_full_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (start_out) o_full_q <= 1'b1;
			else if (pop) o_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start_out) begin
			out_num_q <= o_num_q;
			out_den_q <= o_den_q;
			out_eq_q <= o_eq_q;
			out_st_q <= o_st_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			rau_pkg::B_IDLE: begin
				cmd_q <= q_cmd;
				o_num_q <= '0;
				o_den_q <= 31'd1;
				o_eq_q <= 1'b0;
				o_st_q <= q_cmd.st;
			end
			rau_pkg::B_M1: p1_q <= mul;
			rau_pkg::B_M2: begin
				p2_q <= mul;
				o_eq_q <= (cmd_q.kind == rau_pkg::K_CMP) && (p1_q == mul);
			end
			rau_pkg::B_M3: p3_q <= mul;
			rau_pkg::B_M4: begin
				p2_q <= p3_q;
				p3_q <= mul;
			end
			rau_pkg::B_COMB: begin
				neg_q <= (n_s < 0) != (d_s < 0);
				nm_q <= (n_s < 0) ? PW'(-n_s) : PW'(n_s);
				dm_q <= (d_s < 0) ? PW'(-d_s) : PW'(d_s);
				gx_q <= (n_s < 0) ? PW'(-n_s) : PW'(n_s);
				gy_q <= (d_s < 0) ? PW'(-d_s) : PW'(d_s);
				cnt_q <= '0;
			end
			rau_pkg::B_GCD: begin
				if (gdone) begin
					g_q <= gy_q << cnt_q;
					quo_q <= nm_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
					cnt_q <= cnt_q + CW'(1);
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (gx_q >= gy_q) begin
					gx_q <= gdiff >> 1;
				end else begin
					gy_q <= gdiff >> 1;
				end
			end
			rau_pkg::B_DIVN, rau_pkg::B_DIVD: begin
				if (cnt_q == CW'(PW)) begin
					if (st_q == rau_pkg::B_DIVN) begin
						rn_q <= quo_q;
						quo_q <= dm_q;
					end else begin
						rd_q <= quo_q;
					end
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
					if (!trial[PW]) begin
						rem_q <= trial[PW-1:0];
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[PW-2:0], quo_q[PW-1]};
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
				end
			end
			rau_pkg::B_FIT: begin
				if (rn_q == '0) begin
					o_num_q <= '0;
					o_den_q <= 31'd1;
				end else if (rd_q > lim - PW'(1) ||
						rn_q > (neg_q ? lim : lim - PW'(1))) begin
					o_st_q <= rau_pkg::ST_OVERFLOW;
				end else begin
					o_num_q <= neg_q ? 32'(-rn_q) : 32'(rn_q);
					o_den_q <= 31'(rd_q);
				end
			end
			default: ;
		endcase
	end

	assign res_num = out_num_q;
	assign res_den = out_den_q;
	assign is_equal = out_eq_q;
	assign status = out_st_q;

	`RAU_ASSERT_IMP(a_take_idle, clk, arst_n, q_take, st_q == rau_pkg::B_IDLE)
	`RAU_ASSERT_IMP(a_den_ok, clk, arst_n, o_full_q, res_den != '0)
	`RAU_ASSERT_IMP(a_st_clean, clk, arst_n, o_full_q && status != rau_pkg::ST_OK,
		res_num == '0 && !is_equal)
endmodule

### rtl/rational_arith_unit_core.sv
// errors and unused ops pass from B_IDLE straight to B_OUT; compare ends after B_M1 and B_M2
// arithmetic: multiply steps B_M1 to B_M3 (plus B_M4 for multiply), a binary gcd, two divisions, a fit
// one item in the back end at a time; a two-entry queue decouples the front
// a result register lets the next item start while one waits; B_OUT stalls until it is free
// arst_n clears queue pointers, sequencer state and the result valid flag
module rational_arith_unit_core #(
	parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [2:0] op,
	input logic [31:0] a_num,
	input logic [30:0] a_den,
	input logic [31:0] b_num,
	input logic [30:0] b_den,
	output logic empty,
	input logic pop,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic is_equal,
	output logic [1:0] status
);
	logic q_valid, q_take;
	rau_pkg::cmd_t q_cmd;

	rau_front #(.WIDTH(WIDTH)) u_front (
		.clk, .arst_n, .push, .full, .op, .a_num, .a_den, .b_num, .b_den,
		.q_valid, .q_cmd, .q_take
	);

	rau_back #(.WIDTH(WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_take, .empty, .pop,
		.res_num, .res_den, .is_equal, .status
	);
endmodule

### tb/tb_rational_arith_unit_core.sv
module tb_rational_arith_unit_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam logic [127:0] NUM_LIM = 128'h8000_0000;

	typedef struct {
		logic [2:0] op;
		logic signed [31:0] an;
		logic [30:0] ad;
		logic signed [31:0] bn;
		logic [30:0] bd;
	} frac_pair_t;

	typedef struct {
		logic [31:0] num;
		logic [30:0] den;
		logic eq;
		logic [1:0] st;
	} frac_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [2:0] op = '0;
	logic [31:0] a_num = '0;
	logic [30:0] a_den = '0;
	logic [31:0] b_num = '0;
	logic [30:0] b_den = '0;
	logic empty;
	logic pop = 1'b0;
	logic [31:0] res_num;
	logic [30:0] res_den;
	logic is_equal;
	logic [1:0] status;

	frac_res_t expected_q[$];
	int errors = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold_left = 0;
	longint cycles = 0;

	rational_arith_unit_core i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .op(op),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.empty(empty), .pop(pop), .res_num(res_num), .res_den(res_den),
		.is_equal(is_equal), .status(status)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [127:0] gcd128(input logic [127:0] x, input logic [127:0] y);
		logic [127:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_res_t reduce_frac(input frac_pair_t it);
		frac_res_t r;
		logic signed [127:0] an, ad, bn, bd, n, d;
		logic [127:0] nm, dm, g;
		logic neg, arith;
		an = it.an;
		bn = it.bn;
		ad = {97'd0, it.ad};
		bd = {97'd0, it.bd};
		r = '{num: '0, den: 31'd1, eq: 1'b0, st: rau_pkg::ST_OK};
		arith = 1'b0;
		n = 0;
		d = 1;
		if (it.op <= rau_pkg::OP_CMP && (it.ad == 0 || it.bd == 0)) begin
			r.st = rau_pkg::ST_DIVZERO;
		end else begin
			case (it.op)
				rau_pkg::OP_ADD: begin
					n = an * bd + bn * ad; d = ad * bd; arith = 1'b1;
				end
				rau_pkg::OP_SUB: begin
					n = an * bd - bn * ad; d = ad * bd; arith = 1'b1;
				end
				rau_pkg::OP_MUL: begin n = an * bn; d = ad * bd; arith = 1'b1; end
				rau_pkg::OP_DIV: begin
					if (it.bn == 0) begin
						r.st = rau_pkg::ST_DIVZERO;
					end else begin
						n = an * bd;
						d = ad * bn;
						arith = 1'b1;
					end
				end
				rau_pkg::OP_CMP: r.eq = (an * bd == bn * ad);
				default: ;
			endcase
		end
		if (arith) begin
			neg = (n < 0) != (d < 0);
			nm = (n < 0) ? -n : n;
			dm = (d < 0) ? -d : d;
			g = gcd128(nm, dm);
			if (g == 0)
				g = 1;
			nm = nm / g;
			dm = dm / g;
			if (nm == 0) begin
				neg = 1'b0;
				dm = 1;
			end
			if (dm > NUM_LIM - 1 || nm > (neg ? NUM_LIM : NUM_LIM - 1)) begin
				r.st = rau_pkg::ST_OVERFLOW;
			end else begin
				r.num = neg ? -nm[31:0] : nm[31:0];
				r.den = dm[30:0];
			end
		end
		if (r.st != rau_pkg::ST_OK) begin
			r.num = '0;
			r.den = 31'd1;
			r.eq = 1'b0;
		end
		return r;
	endfunction

	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			pop <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			pop <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		frac_res_t exp_r;
		if (arst_n && pop && !empty) begin
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (res_num !== exp_r.num) begin
					$error("res_num expected %0d got %0d", $signed(exp_r.num), $signed(res_num));
					errors++;
				end
				if (res_den !== exp_r.den) begin
					$error("res_den expected %0d got %0d", exp_r.den, res_den);
					errors++;
				end
				if (is_equal !== exp_r.eq) begin
					$error("is_equal expected %0d got %0d", exp_r.eq, is_equal);
					errors++;
				end
				if (status !== exp_r.st) begin
					$error("status expected %0d got %0d", exp_r.st, status);
					errors++;
				end
			end
		end
	end

	task automatic send_item(input frac_pair_t it);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		op <= it.op;
		a_num <= it.an;
		a_den <= it.ad;
		b_num <= it.bn;
		b_den <= it.bd;
		do
			@(posedge clk);
		while (full);
		expected_q.push_back(reduce_frac(it));
	endtask

	task automatic stop_sending();
		@(negedge clk);
		push <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic frac_pair_t mk(input logic [2:0] o, input int an, input int ad,
			input int bn, input int bd);
		frac_pair_t it;
		it.op = o;
		it.an = an;
		it.ad = ad[30:0];
		it.bn = bn;
		it.bd = bd[30:0];
		return it;
	endfunction

	function automatic logic signed [31:0] rand_num();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 200)) - 100;
			2: return $signed($urandom_range(0, 20000)) - 10000;
			default: return $urandom() >>> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [30:0] rand_den();
		case ($urandom_range(0, 31))
			0: return '0;
			1, 2, 3, 4, 5, 6, 7: return 31'($urandom());
			8, 9, 10, 11, 12: return 31'($urandom() >> $urandom_range(1, 31));
			default: return 31'($urandom_range(1, 120));
		endcase
	endfunction

	function automatic frac_pair_t rand_item();
		frac_pair_t it;
		int k;
		it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) :
			3'($urandom_range(0, 4));
		it.an = rand_num();
		it.ad = rand_den();
		it.bn = rand_num();
		it.bd = rand_den();
		if (it.op == rau_pkg::OP_CMP && $urandom_range(0, 1)) begin
			k = $urandom_range(1, 50);
			it.an = $signed($urandom_range(0, 2000)) - 1000;
			it.ad = 31'($urandom_range(1, 1000));
			it.bn = it.an * k;
			it.bd = 31'(it.ad * k);
		end
		return it;
	endfunction

	task automatic test_directed();
		send_item(mk(rau_pkg::OP_ADD, 1, 2, 1, 3));
		send_item(mk(rau_pkg::OP_SUB, 1, 2, 1, 2));
		send_item(mk(rau_pkg::OP_SUB, -3, 4, 5, 6));
		send_item(mk(rau_pkg::OP_MUL, 2, 3, -9, 4));
		send_item(mk(rau_pkg::OP_DIV, 2, 3, -4, 9));
		send_item(mk(rau_pkg::OP_DIV, 5, 7, 0, 3));
		send_item(mk(rau_pkg::OP_CMP, 1, 2, 2, 4));
		send_item(mk(rau_pkg::OP_CMP, 1, 2, 2, 5));
		send_item(mk(rau_pkg::OP_ADD, 1, 0, 1, 1));
		send_item(mk(rau_pkg::OP_CMP, 1, 1, 1, 0));
		send_item(mk(rau_pkg::OP_MUL, 32'h7fffffff, 1, 32'h7fffffff, 1));
		send_item(mk(rau_pkg::OP_MUL, 32'h80000000, 1, -1, 1));
		send_item(mk(rau_pkg::OP_DIV, 32'h80000000, 1, 1, 1));
		send_item(mk(rau_pkg::OP_DIV, 1, 32'h7fffffff, -1, 32'h7fffffff));
		send_item(mk(rau_pkg::OP_MUL, 1, 32'h7fffffff, 1, 32'h7fffffff));
		send_item(mk(rau_pkg::OP_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff));
		send_item(mk(rau_pkg::OP_SUB, 32'h7fffffff, 3, 32'h80000000, 5));
		send_item(mk(rau_pkg::OP_ADD, 0, 7, 0, 9));
		send_item(mk(3'd5, 3, 4, 5, 6));
		send_item(mk(3'd6, 0, 0, 0, 0));
		send_item(mk(3'd7, -1, 32'h7fffffff, -1, 32'h7fffffff));
		send_item(mk(rau_pkg::OP_CMP, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff));
		wait_drained();
	endtask

	task automatic test_random(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (count)
			send_item(rand_item());
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		@(posedge clk);
		rx_hold_left = 1500;
		repeat (10)
			send_item(rand_item());
		wait_drained();
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random(340, 12, 85);
		test_random(340, 85, 12);
		test_random(340, 0, 0);
		repeat (400)
			@(posedge clk);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
